// ===== design/scdpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// scdpwm_pkg: shared types and constants for the swing clock divider
// Field widths, register indexes, reset values, the beat ratio table and the
// structs that travel between the timing, multiplier and beat blocks.
// ----------------------------------------------------------------------------
package scdpwm_pkg;

    // Fraction bits of the sample-domain fixed point
    localparam int FRAC_BITS_DEF = 16;

    // Register and field widths
    localparam int UNIT_W      = 32;
    localparam int RATIO_SEL_W = 5;
    localparam int SWING_W     = 16;
    localparam int PWIDTH_W    = 17;
    localparam int RST_LEN_W   = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;

    // Beat ratio table: counts of 1/96 quarter notes
    localparam int RATIO_CNT_W = 13;

    // Beat period, phase and pulse length widths
    localparam int PER_W       = UNIT_W + RATIO_CNT_W;
    localparam int PH_W        = 48;
    localparam int PWIDTH_FRAC = 16;
    localparam int HIGH_W      = PER_W + PWIDTH_W - PWIDTH_FRAC;

    // Serial multiplier: PER_W multiplicand, widest fraction as multiplier
    localparam int MUL_B_W = PWIDTH_W;
    localparam int PROD_W  = PER_W + MUL_B_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_SELECT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWING_AMOUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_PULSE_LEN = 3'd4;

    // Register reset values
    localparam logic [UNIT_W-1:0]      UNIT_LENGTH_RST     = 32'd16384000;
    localparam logic [RATIO_SEL_W-1:0] RATIO_SELECT_RST    = 5'd15;
    localparam logic [SWING_W-1:0]     SWING_AMOUNT_RST    = 16'd0;
    localparam logic [PWIDTH_W-1:0]    PULSE_WIDTH_RST     = 17'd32768;
    localparam logic [RST_LEN_W-1:0]   RESET_PULSE_LEN_RST = 16'd48;

    typedef struct packed {
        logic [UNIT_W-1:0]      unit_length;
        logic [RATIO_SEL_W-1:0] ratio_select;
        logic [SWING_W-1:0]     swing_amount;
        logic [PWIDTH_W-1:0]    pulse_width;
        logic [RST_LEN_W-1:0]   reset_pulse_len;
    } cfg_t;

    // Beat timing derived from the registers, all in sample fixed point
    typedef struct packed {
        logic              valid;
        logic [PER_W-1:0]  period;
        logic [PER_W-1:0]  delay;
        logic [HIGH_W-1:0] high_len;
    } timing_t;

    typedef struct packed {
        logic               start;
        logic [PER_W-1:0]   a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

    typedef enum logic [1:0] {
        TM_IDLE,
        TM_PERIOD,
        TM_SWING,
        TM_WIDTH
    } tm_state_t;

    typedef enum logic [2:0] {
        BT_IDLE,
        BT_EDGE,
        BT_WRAP,
        BT_WRAP2,
        BT_FIRE,
        BT_PULSE,
        BT_DONE
    } bt_state_t;

    // Selections past the end of the table use the last entry
    function automatic logic [RATIO_CNT_W-1:0] ratio_count(input logic [RATIO_SEL_W-1:0] sel);
        logic [RATIO_CNT_W-1:0] cnt;
        case (sel)
            5'd0:    cnt = 13'd6144;
            5'd1:    cnt = 13'd3072;
            5'd2:    cnt = 13'd1536;
            5'd3:    cnt = 13'd768;
            5'd4:    cnt = 13'd384;
            5'd5:    cnt = 13'd288;
            5'd6:    cnt = 13'd192;
            5'd7:    cnt = 13'd144;
            5'd8:    cnt = 13'd128;
            5'd9:    cnt = 13'd96;
            5'd10:   cnt = 13'd72;
            5'd11:   cnt = 13'd64;
            5'd12:   cnt = 13'd48;
            5'd13:   cnt = 13'd36;
            5'd14:   cnt = 13'd32;
            5'd15:   cnt = 13'd24;
            5'd16:   cnt = 13'd18;
            5'd17:   cnt = 13'd16;
            5'd18:   cnt = 13'd12;
            5'd19:   cnt = 13'd9;
            5'd20:   cnt = 13'd8;
            5'd21:   cnt = 13'd6;
            default: cnt = 13'd3;
        endcase
        return cnt;
    endfunction

endpackage

// ===== design/swing_clock_divider_pwm.sv =====
// ----------------------------------------------------------------------------
// swing_clock_divider_pwm: tempo clock divider with swing and pulse width
// Each input word is one sample tick; each output word gives the clock, run
// and reset levels for that sample.
// ----------------------------------------------------------------------------
// While running, a sample word steps through the edge, wrap, fire, pulse and
// done states, with a second wrap state on a sample where the phase has
// reached the beat period and wraps, which happens at every beat boundary and
// after a period change; while stopped it goes from edge straight to done. The
// beat sequencer performs one 48-bit add or compare per cycle and takes no new
// word until the last has left the done state. The output word sits in a
// register, so the next word is taken while a result waits. After reset and
// after any register write, the period, swing delay and pulse length are
// rebuilt on a bit-serial multiplier, one multiplier bit per cycle, three
// products of at most 13, 16 and 17 bits; no sample word is accepted meanwhile.
// ----------------------------------------------------------------------------
module swing_clock_divider_pwm #(
    parameter int FRAC_BITS = scdpwm_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_run_level,
    input  logic                                 s_reset_level,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_clock_out,
    output logic                                 m_run_out,
    output logic                                 m_reset_out,
    input  logic                                 cfg_we,
    input  logic [scdpwm_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [scdpwm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import scdpwm_pkg::*;

    cfg_t    cfg_reg;
    timing_t timing;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unit_length     <= UNIT_LENGTH_RST;
            cfg_reg.ratio_select    <= RATIO_SELECT_RST;
            cfg_reg.swing_amount    <= SWING_AMOUNT_RST;
            cfg_reg.pulse_width     <= PULSE_WIDTH_RST;
            cfg_reg.reset_pulse_len <= RESET_PULSE_LEN_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_UNIT_LENGTH:     cfg_reg.unit_length     <= cfg_wdata[UNIT_W-1:0];
                REG_RATIO_SELECT:    cfg_reg.ratio_select    <= cfg_wdata[RATIO_SEL_W-1:0];
                REG_SWING_AMOUNT:    cfg_reg.swing_amount    <= cfg_wdata[SWING_W-1:0];
                REG_PULSE_WIDTH:     cfg_reg.pulse_width     <= cfg_wdata[PWIDTH_W-1:0];
                REG_RESET_PULSE_LEN: cfg_reg.reset_pulse_len <= cfg_wdata[RST_LEN_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    scdpwm_timing #(
        .FRAC_BITS (FRAC_BITS)
    ) u_timing (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cfg_we  (cfg_we),
        .timing  (timing)
    );

    scdpwm_beat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_beat (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .timing          (timing),
        .reset_pulse_len (cfg_reg.reset_pulse_len),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_run_level     (s_run_level),
        .s_reset_level   (s_reset_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_clock_out     (m_clock_out),
        .m_run_out       (m_run_out),
        .m_reset_out     (m_reset_out)
    );

    // a register write must block sample words until timing is rebuilt
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("sample word accepted right after a register write");

    a_timing_drop_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(timing.valid) |-> $past(cfg_we))
        else $error("timing went stale without a register write");

    a_one_word_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second sample word accepted while one is in flight");

    a_clock_needs_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clock_out) |-> m_run_out)
        else $error("clock high on a stopped sample");

endmodule

// ===== design/scdpwm_ser_mul.sv =====
// ----------------------------------------------------------------------------
// scdpwm_ser_mul: bit-serial shift-add multiplier
// Consumes the multiplier one bit per cycle from a shift register, LSB first,
// and stops as soon as no set bits remain.
// ----------------------------------------------------------------------------
module scdpwm_ser_mul (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  scdpwm_pkg::mul_req_t  req,
    output scdpwm_pkg::mul_rsp_t  rsp
);
    import scdpwm_pkg::*;

    logic               run_reg, run_next;
    logic [PROD_W-1:0]  a_reg, a_next;
    logic [MUL_B_W-1:0] b_reg, b_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;

    always_comb begin
        run_next = run_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        if (req.start) begin
            run_next = 1'b1;
            a_next   = PROD_W'(req.a);
            b_next   = req.b;
            acc_next = '0;
        end else if (run_reg) begin
            if (b_reg == '0) begin
                run_next = 1'b0;
            end else begin
                if (b_reg[0]) begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = a_reg << 1;
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done = run_reg && (b_reg == '0);
    assign rsp.prod = acc_reg;

endmodule

// ===== design/scdpwm_timing.sv =====
// ----------------------------------------------------------------------------
// scdpwm_timing: beat period, swing delay and pulse length
// Recomputes the three products on the serial multiplier after reset and
// after every register write, and holds them for the beat sequencer.
// ----------------------------------------------------------------------------
module scdpwm_timing #(
    parameter int FRAC_BITS = scdpwm_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scdpwm_pkg::cfg_t     cfg,
    input  logic                 cfg_we,
    output scdpwm_pkg::timing_t  timing
);
    import scdpwm_pkg::*;

    // Swing delay is kept in whole samples
    localparam int DLY_W   = PER_W - FRAC_BITS;
    localparam int DLY_LSB = SWING_W + FRAC_BITS;
    localparam int DLY_MSB = PER_W + SWING_W - 1;
    localparam int HI_MSB  = PER_W + PWIDTH_W - 1;

    tm_state_t         state_reg, state_next;
    logic              dirty_reg, dirty_next;
    logic [PER_W-1:0]  period_reg, period_next;
    logic [DLY_W-1:0]  delay_reg, delay_next;
    logic [HIGH_W-1:0] high_reg, high_next;
    mul_req_t          mreq;
    mul_rsp_t          mrsp;

    scdpwm_ser_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            TM_IDLE:   if (dirty_reg) state_next = TM_PERIOD;
            TM_PERIOD: if (mrsp.done) state_next = TM_SWING;
            TM_SWING:  if (mrsp.done) state_next = TM_WIDTH;
            TM_WIDTH:  if (mrsp.done) state_next = TM_IDLE;
            default:   state_next = TM_IDLE;
        endcase
    end

    always_comb begin
        mreq        = '0;
        dirty_next  = dirty_reg;
        period_next = period_reg;
        delay_next  = delay_reg;
        high_next   = high_reg;
        case (state_reg)
            TM_IDLE: begin
                if (dirty_reg) begin
                    mreq.start = 1'b1;
                    mreq.a     = PER_W'(cfg.unit_length);
                    mreq.b     = MUL_B_W'(ratio_count(cfg.ratio_select));
                    dirty_next = 1'b0;
                end
            end
            TM_PERIOD: begin
                // chain straight into the swing product
                if (mrsp.done) begin
                    period_next = mrsp.prod[PER_W-1:0];
                    mreq.start  = 1'b1;
                    mreq.a      = mrsp.prod[PER_W-1:0];
                    mreq.b      = MUL_B_W'(cfg.swing_amount);
                end
            end
            TM_SWING: begin
                if (mrsp.done) begin
                    delay_next = mrsp.prod[DLY_MSB:DLY_LSB];
                    mreq.start = 1'b1;
                    mreq.a     = period_reg;
                    mreq.b     = MUL_B_W'(cfg.pulse_width);
                end
            end
            TM_WIDTH: begin
                if (mrsp.done) begin
                    high_next = mrsp.prod[HI_MSB:PWIDTH_FRAC];
                end
            end
            default: begin
                dirty_next = 1'b1;
            end
        endcase
        if (cfg_we) begin
            dirty_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TM_IDLE;
            dirty_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            dirty_reg <= dirty_next;
        end
        period_reg <= period_next;
        delay_reg  <= delay_next;
        high_reg   <= high_next;
    end

    assign timing.valid    = (state_reg == TM_IDLE) && !dirty_reg;
    assign timing.period   = period_reg;
    assign timing.delay    = {delay_reg, {FRAC_BITS{1'b0}}};
    assign timing.high_len = high_reg;

endmodule

// ===== design/scdpwm_beat.sv =====
// ----------------------------------------------------------------------------
// scdpwm_beat: per-sample beat sequencer
// Steps one sample word through edge handling and, while running, phase wrap,
// fire test, pulse countdown and phase advance, one wide add or compare per cycle.
// ----------------------------------------------------------------------------
module scdpwm_beat #(
    parameter int FRAC_BITS = scdpwm_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  scdpwm_pkg::timing_t                 timing,
    input  logic [scdpwm_pkg::RST_LEN_W-1:0]    reset_pulse_len,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_run_level,
    input  logic                                s_reset_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_clock_out,
    output logic                                m_run_out,
    output logic                                m_reset_out
);
    import scdpwm_pkg::*;

    localparam logic [PH_W-1:0]   ONE_PH = PH_W'(1) << FRAC_BITS;
    localparam logic [HIGH_W-1:0] ONE_HI = HIGH_W'(1) << FRAC_BITS;

    bt_state_t            state_reg, state_next;
    logic [PH_W-1:0]      phase_reg, phase_next;
    logic                 odd_reg, odd_next;
    logic [HIGH_W-1:0]    pulse_rem_reg, pulse_rem_next;
    logic [RST_LEN_W-1:0] rst_rem_reg, rst_rem_next;
    logic                 run_prev_reg, run_prev_next;
    logic                 rst_prev_reg, rst_prev_next;
    logic                 run_reg, run_next;
    logic                 rst_reg, rst_next;
    logic                 clk_reg, clk_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_clock_reg, m_clock_next;
    logic                 m_run_reg, m_run_next;
    logic                 m_reset_reg, m_reset_next;

    logic                 accept;
    logic                 out_free;
    logic                 rise;
    logic [PH_W:0]        ph_minus_per;
    logic [PH_W-1:0]      dly_ph;
    logic [PH_W:0]        ph_minus_dly;
    logic                 fire;

    assign s_ready  = (state_reg == BT_IDLE) && timing.valid;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rise     = (run_reg && !run_prev_reg) || (rst_reg && !rst_prev_reg);

    assign ph_minus_per = {1'b0, phase_reg} - {1'b0, PH_W'(timing.period)};
    assign dly_ph       = odd_reg ? PH_W'(timing.delay) : '0;
    assign ph_minus_dly = {1'b0, phase_reg} - {1'b0, dly_ph};
    // phase sits within one sample past the (possibly swung) beat point
    assign fire = !ph_minus_dly[PH_W] && (ph_minus_dly[PH_W-1:FRAC_BITS] == '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BT_IDLE:  if (accept) state_next = BT_EDGE;
            BT_EDGE:  state_next = run_reg ? BT_WRAP : BT_DONE;
            BT_WRAP:  state_next = ph_minus_per[PH_W] ? BT_FIRE : BT_WRAP2;
            BT_WRAP2: state_next = BT_FIRE;
            BT_FIRE:  state_next = BT_PULSE;
            BT_PULSE: state_next = BT_DONE;
            BT_DONE:  if (out_free) state_next = BT_IDLE;
            default:  state_next = BT_IDLE;
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        odd_next       = odd_reg;
        pulse_rem_next = pulse_rem_reg;
        rst_rem_next   = rst_rem_reg;
        run_prev_next  = run_prev_reg;
        rst_prev_next  = rst_prev_reg;
        run_next       = run_reg;
        rst_next       = rst_reg;
        clk_next       = clk_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_clock_next   = m_clock_reg;
        m_run_next     = m_run_reg;
        m_reset_next   = m_reset_reg;
        case (state_reg)
            BT_IDLE: begin
                if (accept) begin
                    run_next = s_run_level;
                    rst_next = s_reset_level;
                end
            end
            BT_EDGE: begin
                run_prev_next = run_reg;
                rst_prev_next = rst_reg;
                clk_next      = 1'b0;
                if (rise) begin
                    if (reset_pulse_len > rst_rem_reg) begin
                        rst_rem_next = reset_pulse_len;
                    end
                    phase_next     = '0;
                    odd_next       = 1'b0;
                    pulse_rem_next = '0;
                end
            end
            BT_WRAP: begin
                if (!ph_minus_per[PH_W]) begin
                    phase_next = ph_minus_per[PH_W-1:0];
                    odd_next   = !odd_reg;
                end
            end
            BT_WRAP2: begin
                // still past the period after one wrap: restart the beat
                if (!ph_minus_per[PH_W]) begin
                    phase_next = '0;
                end
            end
            BT_FIRE: begin
                if (fire && (timing.high_len > pulse_rem_reg)) begin
                    pulse_rem_next = timing.high_len;
                end
            end
            BT_PULSE: begin
                if (pulse_rem_reg != '0) begin
                    clk_next       = 1'b1;
                    pulse_rem_next = (pulse_rem_reg > ONE_HI) ? (pulse_rem_reg - ONE_HI) : '0;
                end
                phase_next = phase_reg + ONE_PH;
            end
            BT_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_clock_next = clk_reg;
                    m_run_next   = run_reg;
                    m_reset_next = (rst_rem_reg != '0);
                    if (rst_rem_reg != '0) begin
                        rst_rem_next = rst_rem_reg - 1'b1;
                    end
                end
            end
            default: begin
                clk_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BT_IDLE;
            phase_reg     <= '0;
            odd_reg       <= 1'b0;
            pulse_rem_reg <= '0;
            rst_rem_reg   <= '0;
            run_prev_reg  <= 1'b0;
            rst_prev_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            odd_reg       <= odd_next;
            pulse_rem_reg <= pulse_rem_next;
            rst_rem_reg   <= rst_rem_next;
            run_prev_reg  <= run_prev_next;
            rst_prev_reg  <= rst_prev_next;
            m_valid_reg   <= m_valid_next;
        end
        run_reg     <= run_next;
        rst_reg     <= rst_next;
        clk_reg     <= clk_next;
        m_clock_reg <= m_clock_next;
        m_run_reg   <= m_run_next;
        m_reset_reg <= m_reset_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_clock_out = m_clock_reg;
    assign m_run_out   = m_run_reg;
    assign m_reset_out = m_reset_reg;

endmodule
